// ===== rtl/aks_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for the AES-128 key schedule.
package aks_pkg;

   localparam int KEY_BITS = 128;
   localparam int RK_COUNT = 11;           // forward round keys 0..10
   localparam logic [4:0] FWD_LAST  = 5'd10;
   localparam logic [4:0] INV_FIRST = 5'd11;
   localparam logic [4:0] LAST_SLOT = 5'd20;
   localparam logic [4:0] SLOT_END  = 5'd21;
   localparam logic [7:0] RCON_INIT = 8'h01;
   localparam logic [7:0] GF_POLY   = 8'h1b;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FWD,
      ST_INV
   } seq_state_type;

   typedef struct packed {
      logic load;   // take a new cipher key, rcon back to 1
      logic step;   // advance to the next round key
   } expand_ctl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic logic [7:0] sbox(input logic [7:0] v);
      return SBOX[v];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   // InvMixColumns of one column, a0 in the top byte
   function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
      logic [7:0] a [4];
      logic [7:0] m2 [4];
      logic [7:0] m4 [4];
      logic [7:0] m8 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      for (int i = 0; i < 4; i++) begin
         a[i]  = col[31-8*i -: 8];
         m2[i] = xtime(a[i]);
         m4[i] = xtime(m2[i]);
         m8[i] = xtime(m4[i]);
         m9[i] = m8[i] ^ a[i];
         mb[i] = m8[i] ^ m2[i] ^ a[i];
         md[i] = m8[i] ^ m4[i] ^ a[i];
         me[i] = m8[i] ^ m4[i] ^ m2[i];
      end
      return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
              m9[0] ^ me[1] ^ mb[2] ^ md[3],
              md[0] ^ m9[1] ^ me[2] ^ mb[3],
              mb[0] ^ md[1] ^ m9[2] ^ me[3]};
   endfunction

   function automatic logic [KEY_BITS-1:0] inv_mix(input logic [KEY_BITS-1:0] w);
      logic [KEY_BITS-1:0] r;
      for (int c = 0; c < 4; c++) begin
         r[127-32*c -: 32] = inv_mix_col(w[127-32*c -: 32]);
      end
      return r;
   endfunction

   // one step of the forward expansion; byte 0 sits in the top bits
   function automatic logic [KEY_BITS-1:0] next_round_key(input logic [KEY_BITS-1:0] p,
                                                          input logic [7:0] rcon);
      logic [31:0] t;
      logic [31:0] q0;
      logic [31:0] q1;
      logic [31:0] q2;
      logic [31:0] q3;
      t  = {sbox(p[23:16]) ^ rcon, sbox(p[15:8]), sbox(p[7:0]), sbox(p[31:24])};
      q0 = p[127:96] ^ t;
      q1 = p[95:64] ^ q0;
      q2 = p[63:32] ^ q1;
      q3 = p[31:0] ^ q2;
      return {q0, q1, q2, q3};
   endfunction

endpackage

// ===== rtl/aes128_key_schedule.sv =====
// Top level of the AES-128 key schedule: sequencer, round key RAM, output register.
//
// Usage:
//  - req channel: one transaction carries a 128-bit cipher key. tdata[63:0] is
//    key_high (key bytes 0..7, byte 0 on top), tdata[127:64] is key_low.
//  - rsp channel: 21 transactions per key, slot 0..20. Slots 0..10 are the
//    forward round keys 0..10, slots 11..19 InvMixColumns of round keys 9
//    down to 1, slot 20 is round key 0 again. tlast marks slot 20.
//  - Forward keys come one per cycle from the expansion register while the
//    output is not stalled, and are written to an 11-entry round key RAM.
//    The inverse part reads that RAM back through its registered read and
//    runs InvMixColumns on the way out.
//  - A key goes into the expansion register, then slot 0 into the output
//    register. Without stalls one result leaves per cycle, except for a gap
//    at the turn from the forward to the inverse part while the first RAM
//    read is in flight; the next key can be taken in the cycle after slot 20 is loaded.
//  - req_tready is high only between schedules; the next key can be taken
//    while slot 20 still sits in the output register.
//  - A stalled rsp_tready holds the output register and the sequencer; no
//    word is dropped or repeated, and the RAM read data holds until used.
//  - Reset (synchronous) drops any schedule in progress and empties the
//    output register. The RAM needs no clearing: it is always written first.
module aes128_key_schedule (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] key_high, [127:64] key_low
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // [4:0] slot, [68:5] word_high, [132:69] word_low
   output logic         rsp_tlast    // last
);
   import aks_pkg::*;

   localparam int RAM_AW = $clog2(RK_COUNT);

   seq_state_type state_ff;
   seq_state_type state_in;

   logic [4:0] slot_ff;      // slot of the next word to load into the output
   logic [4:0] slot_in;
   logic [4:0] rd_slot_ff;   // slot of the next RAM read
   logic [4:0] rd_slot_in;
   logic       rdv_ff;       // RAM read data holds an unused word
   logic       rdv_in;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [4:0]   rsp_slot_ff;
   logic [127:0] rsp_word_ff;
   logic         rsp_last_ff;

   logic         req_accept;
   logic         out_free;
   logic         fwd_emit;
   logic         inv_issue;
   logic         inv_consume;
   logic         out_load;
   logic [127:0] out_word;
   logic [127:0] round_key;
   logic [127:0] rd_data;
   logic [4:0]   rd_dist;

   expand_ctl_type expand_ctl;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_FWD;
            end
         end
         ST_FWD: begin
            if (fwd_emit && (slot_ff == FWD_LAST)) begin
               state_in = ST_INV;
            end
         end
         ST_INV: begin
            if (inv_consume && (slot_ff == LAST_SLOT)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready  = 1'b0;
      fwd_emit    = 1'b0;
      inv_consume = 1'b0;
      inv_issue   = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_FWD:  fwd_emit = out_free;
         ST_INV: begin
            inv_consume = rdv_ff && out_free;
            inv_issue   = (rd_slot_ff != SLOT_END) && (!rdv_ff || (rdv_ff && out_free));
         end
         default: req_tready = 1'b0;
      endcase
   end

   assign out_load = fwd_emit || inv_consume;

   assign expand_ctl.load = req_accept;
   assign expand_ctl.step = fwd_emit;

   // key_high goes on top so key byte 0 lands in the top bits
   aks_expand u_expand (
      .clock     (clock),
      .ctl       (expand_ctl),
      .key       ({req_tdata[63:0], req_tdata[127:64]}),
      .round_key (round_key)
   );

   // slot s of the inverse part reads round key 20 - s
   assign rd_dist = LAST_SLOT - rd_slot_ff;

   aks_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (RK_COUNT)
   ) u_rk_ram (
      .clock (clock),
      .we    (fwd_emit),
      .waddr (slot_ff[RAM_AW-1:0]),
      .wdata (round_key),
      .re    (inv_issue),
      .raddr (rd_dist[RAM_AW-1:0]),
      .rdata (rd_data)
   );

   // sequencer counters
   always_comb begin
      slot_in    = slot_ff;
      rd_slot_in = rd_slot_ff;
      rdv_in     = rdv_ff;
      if (req_accept) begin
         slot_in = 5'd0;
         rdv_in  = 1'b0;
      end else if (out_load) begin
         slot_in = slot_ff + 5'd1;
      end
      if (fwd_emit && (slot_ff == FWD_LAST)) begin
         rd_slot_in = INV_FIRST;
      end else if (inv_issue) begin
         rd_slot_in = rd_slot_ff + 5'd1;
      end
      if (state_ff == ST_INV) begin
         rdv_in = inv_issue || (rdv_ff && !inv_consume);
      end
   end

   // round key 0 goes out unchanged at the end
   assign out_word = (state_ff == ST_FWD)    ? round_key :
                     (slot_ff == LAST_SLOT)  ? rd_data   : inv_mix(rd_data);

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= 5'd0;
         rd_slot_ff   <= SLOT_END;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rd_slot_ff   <= rd_slot_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_slot_ff <= slot_ff;
         rsp_word_ff <= out_word;
         rsp_last_ff <= (slot_ff == LAST_SLOT);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_word_ff[63:0], rsp_word_ff[127:64], rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/aks_ram.sv =====
// Generic simple dual-port RAM with registered read.
module aks_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 11
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/aks_expand.sv =====
// Forward key expansion: current round key and round constant registers.
module aks_expand (
   input  logic                    clock,
   input  aks_pkg::expand_ctl_type ctl,
   input  logic [127:0]            key,
   output logic [127:0]            round_key
);
   import aks_pkg::*;

   logic [KEY_BITS-1:0] rk_ff;
   logic [KEY_BITS-1:0] rk_in;
   logic [7:0]          rcon_ff;
   logic [7:0]          rcon_in;

   always_comb begin
      rk_in   = rk_ff;
      rcon_in = rcon_ff;
      if (ctl.load) begin
         rk_in   = key;
         rcon_in = RCON_INIT;
      end else if (ctl.step) begin
         rk_in   = next_round_key(rk_ff, rcon_ff);
         rcon_in = xtime(rcon_ff);
      end
   end

   always_ff @(posedge clock) begin
      rk_ff   <= rk_in;
      rcon_ff <= rcon_in;
   end

   assign round_key = rk_ff;

endmodule

// ===== rtl/aks_checker.sv =====
// Port-level checker for the AES-128 key schedule, bound to the top level.
module aks_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         rsp_tlast
);
   import aks_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // tlast marks exactly slot 20
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[4:0] == LAST_SLOT)))
      else $error("rsp_tlast does not match slot 20");

   // slot never runs past the end of the schedule, pad bits stay zero
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[4:0] < SLOT_END) && (rsp_tdata[135:133] == 3'b000)))
      else $error("rsp slot out of range or pad bits set");

   // req_tready stays low whenever a word other than the last is accepted
   a_no_key_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |-> !req_tready)
      else $error("key taken before schedule finished");

   // reset empties the output
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

endmodule

bind aes128_key_schedule aks_checker u_aks_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
